/* hdl/chemical_formula_parser_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the chemical formula parser
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHEMICAL_FORMULA_PARSER_ASSERT_SVH
`define CHEMICAL_FORMULA_PARSER_ASSERT_SVH

// cond must hold at every clock edge
`define CFP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// when pre holds, post must hold at the next clock edge
`define CFP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/cfp_pkg.sv */
// ---------------------------------------------------------------------------
// cfp_pkg
// Constants, element table, result and event types of the formula parser.
// ---------------------------------------------------------------------------
package cfp_pkg;

    localparam int NUM_ELEMENTS = 30;
    localparam int COUNT_BITS   = 16;

    localparam int CHAR_W     = 8;
    localparam int ELEM_W     = 5;
    localparam int OUT_CNT_W  = 16;
    localparam int ATOM_W     = 16;
    localparam int MASS_W     = 40;
    localparam int WEIGHT_W   = 23;
    localparam int PROD_W     = COUNT_BITS + WEIGHT_W;
    localparam int ATOM_ACC_W = ((COUNT_BITS > ATOM_W) ? COUNT_BITS : ATOM_W) + 1;
    localparam int MASS_ACC_W = ((PROD_W > MASS_W) ? PROD_W : MASS_W) + 1;
    localparam int RESULT_W   = ELEM_W + OUT_CNT_W + ATOM_W + MASS_W;
    localparam int TDATA_W    = ((RESULT_W + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - RESULT_W;

    // power of two: pointers wrap on their own
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CHAR_W-1:0] CHR_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CHR_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHR_LPAREN = 8'h28;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // symbol letters and molar mass (g/mol, 16 fractional bits), H to Zn
    localparam logic [CHAR_W-1:0] ROM_FIRST [30] = '{
        8'h48, 8'h48, 8'h4C, 8'h42, 8'h42, 8'h43, 8'h4E, 8'h4F, 8'h46, 8'h4E,
        8'h4E, 8'h4D, 8'h41, 8'h53, 8'h50, 8'h53, 8'h43, 8'h41, 8'h4B, 8'h43,
        8'h53, 8'h54, 8'h56, 8'h43, 8'h4D, 8'h46, 8'h43, 8'h4E, 8'h43, 8'h5A
    };
    localparam logic [CHAR_W-1:0] ROM_SECOND [30] = '{
        8'h00, 8'h65, 8'h69, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65,
        8'h61, 8'h67, 8'h6C, 8'h69, 8'h00, 8'h00, 8'h6C, 8'h72, 8'h00, 8'h61,
        8'h63, 8'h69, 8'h00, 8'h72, 8'h6E, 8'h65, 8'h6F, 8'h69, 8'h75, 8'h6E
    };
    localparam logic [WEIGHT_W-1:0] ROM_WEIGHT [30] = '{
        23'd66060,   23'd262314,  23'd454885,  23'd590610,  23'd708510,
        23'd787133,  23'd917943,  23'd1048537, 23'd1245079, 23'd1322497,
        23'd1506660, 23'd1592852, 23'd1768260, 23'd1840611, 23'd2029899,
        23'd2101412, 23'd2323448, 23'd2618032, 23'd2562346, 23'd2626552,
        23'd2946230, 23'd3137012, 23'd3338502, 23'd3407616, 23'd3600417,
        23'd3659858, 23'd3862246, 23'd3846531, 23'd4164551, 23'd4284744
    };

    // one closed symbol on its way to the totals
    typedef struct packed {
        logic                  valid;
        logic [ELEM_W-1:0]     elem;
        logic [COUNT_BITS-1:0] count;
        logic                  done;
    } event_t;

    // a character closes at most two symbols; b only ever holds a fresh
    // upper-case symbol that also ends the formula, so its count is 1
    typedef struct packed {
        event_t a;
        event_t b;
    } event_pair_t;

    typedef struct packed {
        event_t              ev;
        logic [PROD_W-1:0]   prod;
    } weighed_t;

    typedef struct packed {
        weighed_t a;
        weighed_t b;
    } weighed_pair_t;

    // last field in the lowest bits
    typedef struct packed {
        logic                 done;
        logic                 status;
        logic [MASS_W-1:0]    mass;
        logic [ATOM_W-1:0]    atom;
        logic [OUT_CNT_W-1:0] count;
        logic [ELEM_W-1:0]    elem;
    } result_t;

    // element number of a symbol, 0 when it is not in the table
    function automatic logic [ELEM_W-1:0] elem_lookup(
        input logic [CHAR_W-1:0] first,
        input logic [CHAR_W-1:0] second
    );
        logic [ELEM_W-1:0] hit;
        hit = '0;
        // descending so the lowest matching entry wins
        for (int i = NUM_ELEMENTS - 1; i >= 0; i--)
        begin
            if (first != '0 && ROM_FIRST[i] == first && ROM_SECOND[i] == second)
            begin
                hit = ELEM_W'(i + 1);
            end
        end
        return hit;
    endfunction

    function automatic logic [WEIGHT_W-1:0] elem_weight(input logic [ELEM_W-1:0] elem);
        logic [WEIGHT_W-1:0] w;
        w = '0;
        for (int i = 0; i < NUM_ELEMENTS; i++)
        begin
            if (elem == ELEM_W'(i + 1))
            begin
                w = ROM_WEIGHT[i];
            end
        end
        return w;
    endfunction

endpackage

/* hdl/chemical_formula_parser.sv */
// ---------------------------------------------------------------------------
// chemical_formula_parser
// Parses formula text and reports each element with running atom and mass totals.
// ---------------------------------------------------------------------------
// Input stream: one ASCII character per transfer on s_tdata; s_tlast marks
// the last character of a formula.
// Output stream: one transfer per closed element symbol, or per formula end
// with no symbol open. m_tuser is the error flag (unknown symbol, element
// number 0), m_tlast marks the last result of a formula, after which the totals
// restart from zero.
// Pipeline: the lookup is registered in the parser, count times mass in the
// weigh stage, then the result is written into the queue and raises m_tvalid.
// Throughput: one character per cycle while s_tready is high. An upper-case
// letter ending a formula with a symbol open yields two results, drained one per
// cycle while m_tready is high. s_tready is low when the 8-entry result queue
// plus results still in the pipe leave fewer than two free slots, so a stalled
// receiver throttles the input after a few transfers and nothing is dropped.
// Reset clears the parse state, the totals and the queue at once.
// ---------------------------------------------------------------------------
module chemical_formula_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cfp_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                         s_tlast,   // end_of_formula
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [4:0] element_number, [20:5] element_count, [36:21] atom_sum,
    // [76:37] mass_sum, upper bits zero
    output logic [cfp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tuser,   // status
    output logic                         m_tlast    // formula_done
);
    import cfp_pkg::*;

    logic              accept;
    event_pair_t       events;
    weighed_pair_t     weighed;
    logic              wr_a, wr_b;
    result_t           result_a, result_b, out_data;
    logic [FIFO_AW:0]  fill;
    logic [FIFO_AW+1:0] pending;

    assign accept = s_tvalid && s_tready;

    // results already promised to the queue
    assign pending = (FIFO_AW + 2)'(fill)
                   + (FIFO_AW + 2)'(events.a.valid) + (FIFO_AW + 2)'(events.b.valid)
                   + (FIFO_AW + 2)'(weighed.a.ev.valid) + (FIFO_AW + 2)'(weighed.b.ev.valid);
    assign s_tready = pending <= (FIFO_AW + 2)'(FIFO_DEPTH - 2);

    cfp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .char_code      (s_tdata),
        .end_of_formula (s_tlast),
        .events_reg     (events)
    );

    cfp_weigh u_weigh (
        .clk         (clk),
        .rst_n       (rst_n),
        .events      (events),
        .weighed_reg (weighed)
    );

    cfp_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .weighed  (weighed),
        .wr_a     (wr_a),
        .result_a (result_a),
        .wr_b     (wr_b),
        .result_b (result_b)
    );

    cfp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_a      (wr_a),
        .data_a    (result_a),
        .wr_b      (wr_b),
        .data_b    (result_b),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .fill      (fill)
    );

    assign m_tdata = {PAD_W'(0), out_data.mass, out_data.atom, out_data.count, out_data.elem};
    assign m_tuser = out_data.status;
    assign m_tlast = out_data.done;

endmodule

/* hdl/cfp_parser.sv */
// ---------------------------------------------------------------------------
// cfp_parser
// Character decode, symbol and count state, table lookup of closed symbols.
// ---------------------------------------------------------------------------
module cfp_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [cfp_pkg::CHAR_W-1:0]     char_code,
    input  logic                           end_of_formula,
    output cfp_pkg::event_pair_t           events_reg
);
    import cfp_pkg::*;

    logic [CHAR_W-1:0]     first_reg,  first_next;
    logic [CHAR_W-1:0]     second_reg, second_next;
    logic [COUNT_BITS-1:0] count_reg,  count_next;
    logic                  digits_reg, digits_next;
    logic                  frac_reg,   frac_next;
    logic                  stop_reg,   stop_next;
    logic                  open_reg,   open_next;
    event_pair_t           events_next;

    logic                  is_upper, is_lower, is_digit, is_dot, is_lparen;
    logic [COUNT_BITS+3:0] count_grow;
    event_t                final_ev;
    logic                  prev_closed;

    assign is_upper  = (char_code >= CHR_UP_A) && (char_code <= CHR_UP_Z);
    assign is_lower  = (char_code >= CHR_LO_A) && (char_code <= CHR_LO_Z);
    assign is_digit  = (char_code >= CHR_ZERO) && (char_code <= CHR_NINE);
    assign is_dot    = (char_code == CHR_DOT);
    assign is_lparen = (char_code == CHR_LPAREN);

    // count * 10 + digit
    assign count_grow = ((COUNT_BITS + 4)'(count_reg) << 3)
                      + ((COUNT_BITS + 4)'(count_reg) << 1)
                      + (COUNT_BITS + 4)'(char_code - CHR_ZERO);

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        digits_next = digits_reg;
        frac_next   = frac_reg;
        stop_next   = stop_reg;
        open_next   = open_reg;
        events_next = '0;
        final_ev    = '0;
        prev_closed = 1'b0;

        if (accept)
        begin
            if (!stop_reg)
            begin
                if (is_upper)
                begin
                    if (open_reg)
                    begin
                        prev_closed         = 1'b1;
                        events_next.a.valid = 1'b1;
                        events_next.a.elem  = elem_lookup(first_reg, second_reg);
                        events_next.a.count = digits_reg ? count_reg : COUNT_BITS'(1);
                        events_next.a.done  = 1'b0;
                    end
                    first_next  = char_code;
                    second_next = '0;
                    count_next  = '0;
                    digits_next = 1'b0;
                    frac_next   = 1'b0;
                    open_next   = 1'b1;
                end
                else if (is_lower || is_digit || is_dot)
                begin
                    // stray character opens a symbol that never matches
                    if (!open_reg)
                    begin
                        first_next  = '0;
                        second_next = '0;
                        count_next  = '0;
                        digits_next = 1'b0;
                        frac_next   = 1'b0;
                        open_next   = 1'b1;
                    end
                    if (is_lower)
                    begin
                        if (second_next != '0)
                        begin
                            first_next = '0;
                        end
                        else
                        begin
                            second_next = char_code;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (!frac_next)
                        begin
                            if (count_grow > (COUNT_BITS + 4)'(COUNT_MAX))
                            begin
                                count_next = COUNT_MAX;
                            end
                            else
                            begin
                                count_next = count_grow[COUNT_BITS-1:0];
                            end
                        end
                        digits_next = 1'b1;
                    end
                    else
                    begin
                        frac_next   = 1'b1;
                        digits_next = 1'b1;
                    end
                end
                else if (is_lparen)
                begin
                    stop_next = 1'b1;
                end
            end

            if (end_of_formula)
            begin
                final_ev.valid = 1'b1;
                final_ev.done  = 1'b1;
                if (open_next)
                begin
                    final_ev.elem  = elem_lookup(first_next, second_next);
                    final_ev.count = digits_next ? count_next : COUNT_BITS'(1);
                end
                if (prev_closed)
                begin
                    events_next.b = final_ev;
                end
                else
                begin
                    events_next.a = final_ev;
                end
                first_next  = '0;
                second_next = '0;
                count_next  = '0;
                digits_next = 1'b0;
                frac_next   = 1'b0;
                stop_next   = 1'b0;
                open_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= '0;
            digits_reg <= 1'b0;
            frac_reg   <= 1'b0;
            stop_reg   <= 1'b0;
            open_reg   <= 1'b0;
            events_reg <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
            digits_reg <= digits_next;
            frac_reg   <= frac_next;
            stop_reg   <= stop_next;
            open_reg   <= open_next;
            events_reg <= events_next;
        end
    end

endmodule

/* hdl/cfp_weigh.sv */
// ---------------------------------------------------------------------------
// cfp_weigh
// Multiply each closed symbol's count by its molar mass from the table.
// ---------------------------------------------------------------------------
module cfp_weigh (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfp_pkg::event_pair_t     events,
    output cfp_pkg::weighed_pair_t   weighed_reg
);
    import cfp_pkg::*;

    weighed_pair_t weighed_next;

    always_comb
    begin
        weighed_next.a.ev   = events.a;
        weighed_next.a.prod = PROD_W'(events.a.count) * PROD_W'(elem_weight(events.a.elem));
        // slot b always carries a count of one
        weighed_next.b.ev   = events.b;
        weighed_next.b.prod = PROD_W'(elem_weight(events.b.elem));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weighed_reg <= '0;
        end
        else
        begin
            weighed_reg <= weighed_next;
        end
    end

endmodule

/* hdl/cfp_accum.sv */
// ---------------------------------------------------------------------------
// cfp_accum
// Saturating atom and mass totals; builds up to two results per cycle.
// ---------------------------------------------------------------------------
module cfp_accum (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfp_pkg::weighed_pair_t   weighed,
    output logic                     wr_a,
    output cfp_pkg::result_t         result_a,
    output logic                     wr_b,
    output cfp_pkg::result_t         result_b
);
    import cfp_pkg::*;

    logic [ATOM_W-1:0]     atom_reg, atom_next;
    logic [MASS_W-1:0]     mass_reg, mass_next;
    logic [ATOM_W-1:0]     atom_a, atom_b;
    logic [MASS_W-1:0]     mass_a, mass_b;
    logic [ATOM_ACC_W-1:0] atom_sum_a, atom_sum_b, count_wide;
    logic [MASS_ACC_W-1:0] mass_sum_a, mass_sum_b;
    logic                  hit_a, hit_b;

    assign hit_a = weighed.a.ev.elem != '0;
    assign hit_b = weighed.b.ev.elem != '0;

    assign count_wide = ATOM_ACC_W'(weighed.a.ev.count);
    assign atom_sum_a = ATOM_ACC_W'(atom_reg) + count_wide;
    assign mass_sum_a = MASS_ACC_W'(mass_reg) + MASS_ACC_W'(weighed.a.prod);

    always_comb
    begin
        atom_a = atom_reg;
        mass_a = mass_reg;
        if (hit_a)
        begin
            atom_a = (atom_sum_a > ATOM_ACC_W'({ATOM_W{1'b1}})) ? '1 : atom_sum_a[ATOM_W-1:0];
            mass_a = (mass_sum_a > MASS_ACC_W'({MASS_W{1'b1}})) ? '1 : mass_sum_a[MASS_W-1:0];
        end
    end

    assign atom_sum_b = ATOM_ACC_W'(atom_a) + ATOM_ACC_W'(1);
    assign mass_sum_b = MASS_ACC_W'(mass_a) + MASS_ACC_W'(weighed.b.prod);

    always_comb
    begin
        atom_b = atom_a;
        mass_b = mass_a;
        if (hit_b)
        begin
            atom_b = (atom_sum_b > ATOM_ACC_W'({ATOM_W{1'b1}})) ? '1 : atom_sum_b[ATOM_W-1:0];
            mass_b = (mass_sum_b > MASS_ACC_W'({MASS_W{1'b1}})) ? '1 : mass_sum_b[MASS_W-1:0];
        end
    end

    always_comb
    begin
        result_a.elem   = weighed.a.ev.elem;
        result_a.count  = (count_wide > ATOM_ACC_W'({OUT_CNT_W{1'b1}}))
                        ? '1 : count_wide[OUT_CNT_W-1:0];
        result_a.atom   = atom_a;
        result_a.mass   = mass_a;
        result_a.status = !hit_a;
        result_a.done   = weighed.a.ev.done;

        result_b.elem   = weighed.b.ev.elem;
        result_b.count  = OUT_CNT_W'(1);
        result_b.atom   = atom_b;
        result_b.mass   = mass_b;
        result_b.status = !hit_b;
        result_b.done   = weighed.b.ev.done;
    end

    assign wr_a = weighed.a.ev.valid;
    assign wr_b = weighed.b.ev.valid;

    // clear the totals once the formula has ended
    always_comb
    begin
        atom_next = atom_reg;
        mass_next = mass_reg;
        if ((wr_a && weighed.a.ev.done) || (wr_b && weighed.b.ev.done))
        begin
            atom_next = '0;
            mass_next = '0;
        end
        else if (wr_a)
        begin
            atom_next = atom_a;
            mass_next = mass_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_reg <= '0;
            mass_reg <= '0;
        end
        else
        begin
            atom_reg <= atom_next;
            mass_reg <= mass_next;
        end
    end

endmodule

/* hdl/cfp_out_fifo.sv */
// ---------------------------------------------------------------------------
// cfp_out_fifo
// Result queue: takes up to two results per cycle, hands out one on out_ready.
// ---------------------------------------------------------------------------
module cfp_out_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_a,
    input  cfp_pkg::result_t            data_a,
    input  logic                        wr_b,
    input  cfp_pkg::result_t            data_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cfp_pkg::result_t            out_data,
    output logic [cfp_pkg::FIFO_AW:0]   fill
);
    import cfp_pkg::*;

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     fill_reg,   fill_next;
    logic                 pop;
    logic [FIFO_AW:0]     push_cnt;

    assign out_valid = fill_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign fill      = fill_reg;
    assign pop       = out_valid && out_ready;
    assign push_cnt  = (FIFO_AW + 1)'(wr_a) + (FIFO_AW + 1)'(wr_b);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt[FIFO_AW-1:0];
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        fill_next   = fill_reg + push_cnt - (FIFO_AW + 1)'(pop);
    end

    // slot b is only written together with slot a
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem[wr_ptr_reg] <= data_a;
        end
        if (wr_b)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= data_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* hdl/cfp_checker.sv */
// ---------------------------------------------------------------------------
// cfp_checker
// Port-level checks of the formula parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "chemical_formula_parser_assert.svh"

module cfp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [cfp_pkg::TDATA_W-1:0]  m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);
    import cfp_pkg::*;

    logic [ELEM_W-1:0]    res_elem;
    logic [ATOM_W-1:0]    res_atom;
    logic [MASS_W-1:0]    res_mass;
    logic [TDATA_W+1:0]   res_word;
    logic                 status_ok;
    logic                 totals_ok;
    logic                 stalled;

    assign res_elem = m_tdata[ELEM_W-1:0];
    assign res_atom = m_tdata[ELEM_W+OUT_CNT_W +: ATOM_W];
    assign res_mass = m_tdata[ELEM_W+OUT_CNT_W+ATOM_W +: MASS_W];
    assign res_word = {m_tlast, m_tuser, m_tdata};
    assign stalled  = m_tvalid && !m_tready;

    // error flag and element number zero go together
    assign status_ok = !m_tvalid || (m_tuser == (res_elem == '0));

    // every weight is nonzero: no atoms means no mass and the other way round
    assign totals_ok = !m_tvalid || ((res_atom == '0) == (res_mass == '0));

    `CFP_ASSERT_HOLDS(a_status_elem, status_ok, "status does not match element number")

    `CFP_ASSERT_HOLDS(a_atom_mass_zero, totals_ok, "atom and mass totals disagree on zero")

    `CFP_ASSERT_NEXT(a_valid_hold, stalled, m_tvalid, "result withdrawn while stalled")

    `CFP_ASSERT_NEXT(a_data_hold, stalled, $stable(res_word), "result changed while stalled")

endmodule

bind chemical_formula_parser cfp_checker u_cfp_checker (.*);

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Streams formula text into the parser under random sender bursts and
// receiver stalls. A scoreboard recomputes each element report, with running
// atom and mass totals, and checks every result transfer field by field.
// ---------------------------------------------------------------------------
module tb;
    import cfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 1200;
    localparam int DRAIN_CYCLES   = 8;

    localparam int CNT_LSB  = ELEM_W;
    localparam int ATOM_LSB = CNT_LSB + OUT_CNT_W;
    localparam int MASS_LSB = ATOM_LSB + ATOM_W;

    localparam logic [MASS_W-1:0] MASS_SAT = '1;
    localparam logic [ATOM_W-1:0] ATOM_SAT = '1;

    // one-letter symbols sit in the low byte, two-letter ones fill both bytes
    localparam logic [15:0] ELEM_SYM [30] = '{
        "H",  "He", "Li", "Be", "B",  "C",  "N",  "O",  "F",  "Ne",
        "Na", "Mg", "Al", "Si", "P",  "S",  "Cl", "Ar", "K",  "Ca",
        "Sc", "Ti", "V",  "Cr", "Mn", "Fe", "Co", "Ni", "Cu", "Zn"
    };
    // g/mol in units of 2^-16
    localparam int unsigned ELEM_WEIGHT [30] = '{
        66060,   262314,  454885,  590610,  708510,  787133,  917943,  1048537,
        1245079, 1322497, 1506660, 1592852, 1768260, 1840611, 2029899, 2101412,
        2323448, 2618032, 2562346, 2626552, 2946230, 3137012, 3338502, 3407616,
        3600417, 3659858, 3862246, 3846531, 4164551, 4284744
    };

    typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } formula_char_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    formula_char_t formula_text[$];

    chemical_formula_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    class formula_scoreboard;
        typedef struct {
            logic [ELEM_W-1:0]    elem;
            logic [OUT_CNT_W-1:0] count;
            logic [ATOM_W-1:0]    atoms;
            logic [MASS_W-1:0]    mass;
            logic                 status;
            logic                 done;
        } element_report_t;

        element_report_t       pending_reports[$];
        logic [CHAR_W-1:0]     sym_first;
        logic [CHAR_W-1:0]     sym_second;
        logic [COUNT_BITS-1:0] count_acc;
        logic                  digits_seen;
        logic                  in_fraction;
        logic                  stopped;
        logic                  sym_open;
        logic [ATOM_W-1:0]     atom_total;
        logic [MASS_W-1:0]     mass_total;
        int                    errors;
        int                    chars;
        int                    formulas;
        int                    reports;
        int                    unknowns;
        int                    pairs;

        function new();
            clear_state();
            errors   = 0;
            chars    = 0;
            formulas = 0;
            reports  = 0;
            unknowns = 0;
            pairs    = 0;
        endfunction

        function void clear_state();
            sym_first   = '0;
            sym_second  = '0;
            count_acc   = '0;
            digits_seen = 1'b0;
            in_fraction = 1'b0;
            stopped     = 1'b0;
            sym_open    = 1'b0;
            atom_total  = '0;
            mass_total  = '0;
        endfunction

        function void open_symbol(logic [CHAR_W-1:0] first);
            sym_first   = first;
            sym_second  = '0;
            count_acc   = '0;
            digits_seen = 1'b0;
            in_fraction = 1'b0;
            sym_open    = 1'b1;
        endfunction

        function int find_element();
            logic [15:0] key;
            key = (sym_second == '0) ? {8'h00, sym_first} : {sym_first, sym_second};
            if (sym_first == '0)
                return -1;
            for (int i = 0; i < NUM_ELEMENTS; i++)
            begin
                if (ELEM_SYM[i] == key)
                    return i;
            end
            return -1;
        endfunction

        function void push_report(int idx, logic [COUNT_BITS-1:0] cnt, logic done);
            element_report_t r;
            r.elem   = (idx < 0) ? '0 : ELEM_W'(idx + 1);
            r.count  = OUT_CNT_W'(cnt);
            r.atoms  = atom_total;
            r.mass   = mass_total;
            r.status = (idx < 0);
            r.done   = done;
            pending_reports.insert(pending_reports.size(), r);
        endfunction

        function void close_symbol(logic done);
            logic [COUNT_BITS-1:0] cnt;
            logic [63:0]           sum;
            int                    idx;
            cnt = digits_seen ? count_acc : COUNT_BITS'(1);
            idx = find_element();
            if (idx >= 0)
            begin
                sum = 64'(atom_total) + 64'(cnt);
                atom_total = (sum > 64'(ATOM_SAT)) ? ATOM_SAT : ATOM_W'(sum);
                sum = 64'(mass_total) + 64'(cnt) * 64'(ELEM_WEIGHT[idx]);
                mass_total = (sum > 64'(MASS_SAT)) ? MASS_SAT : MASS_W'(sum);
            end
            push_report(idx, cnt, done);
        endfunction

        // advance the parse by one accepted character
        function void parse_char(logic [CHAR_W-1:0] c, logic eof);
            int          queued;
            int unsigned acc;
            queued = pending_reports.size();
            chars++;
            if (!stopped)
            begin
                if (c >= CHR_UP_A && c <= CHR_UP_Z)
                begin
                    if (sym_open)
                        close_symbol(1'b0);
                    open_symbol(c);
                end
                else if (c >= CHR_LO_A && c <= CHR_LO_Z)
                begin
                    if (!sym_open)
                        open_symbol('0);
                    // a third letter spoils the symbol
                    if (sym_second != '0)
                        sym_first = '0;
                    else
                        sym_second = c;
                end
                else if (c >= CHR_ZERO && c <= CHR_NINE)
                begin
                    if (!sym_open)
                        open_symbol('0);
                    if (!in_fraction)
                    begin
                        acc = 32'(count_acc) * 10 + 32'(c - CHR_ZERO);
                        count_acc = (acc > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(acc);
                        digits_seen = 1'b1;
                    end
                end
                else if (c == CHR_DOT)
                begin
                    if (!sym_open)
                        open_symbol('0);
                    in_fraction = 1'b1;
                    digits_seen = 1'b1;
                end
                else if (c == CHR_LPAREN)
                begin
                    stopped = 1'b1;
                end
            end
            if (eof)
            begin
                formulas++;
                if (sym_open)
                    close_symbol(1'b1);
                else
                    push_report(-1, '0, 1'b1);
                clear_state();
            end
            if (pending_reports.size() - queued == 2)
                pairs++;
        endfunction

        function void compare_field(string field, logic [63:0] expected, logic [63:0] actual);
            if (expected !== actual)
            begin
                $error("%s: expected %0d, got %0d", field, expected, actual);
                errors++;
            end
        endfunction

        function void check_report(logic [TDATA_W-1:0] data, logic status, logic done);
            element_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result transfer with nothing expected: element_number %0d",
                       data[ELEM_W-1:0]);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            reports++;
            if (want.status)
                unknowns++;
            compare_field("element_number", 64'(want.elem), 64'(data[ELEM_W-1:0]));
            compare_field("element_count", 64'(want.count), 64'(data[CNT_LSB +: OUT_CNT_W]));
            compare_field("atom_sum", 64'(want.atoms), 64'(data[ATOM_LSB +: ATOM_W]));
            compare_field("mass_sum", 64'(want.mass), 64'(data[MASS_LSB +: MASS_W]));
            compare_field("tdata padding", 64'(0), 64'(data[TDATA_W-1:RESULT_W]));
            compare_field("status", 64'(want.status), 64'(status));
            compare_field("formula_done", 64'(want.done), 64'(done));
        endfunction
    endclass

    formula_scoreboard sb;

    function void push_char(logic [CHAR_W-1:0] c);
        formula_char_t fc;
        fc.code    = c;
        fc.is_last = 1'b0;
        formula_text.insert(formula_text.size(), fc);
    endfunction

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(CHAR_W'(s[i]));
    endfunction

    function void end_formula();
        formula_text[formula_text.size() - 1].is_last = 1'b1;
    endfunction

    function void push_symbol();
        int idx;
        if ($urandom_range(0, 9) != 0)
        begin
            idx = $urandom_range(0, NUM_ELEMENTS - 1);
            if (ELEM_SYM[idx][15:8] != 8'h00)
                push_char(ELEM_SYM[idx][15:8]);
            push_char(ELEM_SYM[idx][7:0]);
        end
        else
        begin
            // mostly symbols that are not in the table, some with a third letter
            push_char(CHAR_W'(CHR_UP_A + $urandom_range(0, 25)));
            if ($urandom_range(0, 1) != 0)
                push_char(CHAR_W'(CHR_LO_A + $urandom_range(0, 25)));
            if ($urandom_range(0, 3) == 0)
                push_char(CHAR_W'(CHR_LO_A + $urandom_range(0, 25)));
        end
    endfunction

    function void push_count();
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5, 6: push_text($sformatf("%0d", $urandom_range(1, 99)));
            7: push_text($sformatf("%0d.%0d", $urandom_range(0, 9), $urandom_range(0, 999)));
            8: push_text($sformatf("%0d", $urandom_range(100, 99999)));
            default: push_text($sformatf(".%0d", $urandom_range(0, 9)));
        endcase
    endfunction

    function logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 5))
            0: return CHAR_W'(CHR_UP_A + $urandom_range(0, 25));
            1: return CHAR_W'(CHR_LO_A + $urandom_range(0, 25));
            2: return CHAR_W'(CHR_ZERO + $urandom_range(0, 9));
            3: return ($urandom_range(0, 1) != 0) ? CHR_DOT : CHR_LPAREN;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function void add_random_formula();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                push_symbol();
                push_count();
            end
            if ($urandom_range(0, 9) == 0)
                push_text("(OH)2");
        end
        else if (kind < 72)
        begin
            // pile up heavy atoms to drive both totals into saturation
            n = $urandom_range(4, 6);
            for (int i = 0; i < n; i++)
            begin
                push_text(($urandom_range(0, 1) != 0) ? "Zn" : "Cu");
                push_text($sformatf("%0d", $urandom_range(60000, 99999)));
            end
        end
        else if (kind < 92)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                push_char(noise_char());
        end
        else
        begin
            push_char(($urandom_range(0, 1) != 0) ? CHAR_W'(CHR_UP_A + $urandom_range(0, 25))
                                                   : noise_char());
        end
        end_formula();
    endfunction

    function void build_stimulus();
        int directed_len;
        push_text("CaCO3");
        end_formula();
        // upper-case letter on the last character closes two symbols
        push_text("OH");
        end_formula();
        push_text("Abc");
        end_formula();
        push_text("H.5");
        end_formula();
        push_text("C99999");
        end_formula();
        push_text("5(Zn");
        end_formula();
        push_char(8'hFF);
        end_formula();
        push_char(8'h00);
        end_formula();
        directed_len = formula_text.size();
        while (formula_text.size() < directed_len + RANDOM_CHARS)
            add_random_formula();
    endfunction

    task automatic send_chars();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 12);
        foreach (formula_text[i])
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= formula_text[i].code;
            s_tlast  <= formula_text[i].is_last;
            do @(posedge clk); while (!s_tready);
            burst_left--;
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(1, 12);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // receiver: switch between streaming, random, sparse and held-off stretches
    rx_mode_t rx_mode = RX_STREAM;
    int       rx_left = 0;

    always @(posedge clk)
    begin
        rx_mode_t next_mode;
        next_mode = rx_mode;
        if (rx_left == 0)
        begin
            next_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left <= (next_mode == RX_HOLD) ? $urandom_range(5, 40) : $urandom_range(10, 120);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        rx_mode <= next_mode;
        case (next_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 1) != 0);
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_report(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                sb.parse_char(s_tdata, s_tlast);
        end
    end

    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        sb = new();
        build_stimulus();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_chars();
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Parsed %0d characters in %0d formulas; %0d characters closed two symbols.",
                 sb.chars, sb.formulas, sb.pairs);
        $display("Checked %0d element results, %0d of them unknown or empty symbols.",
                 sb.reports, sb.unknowns);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
